// ----- sv/btsp_pkg.sv -----
package btsp_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int MODE_W         = 2;
    localparam int COUNT_W        = 8;
    localparam int PERIOD_W       = 16;
    localparam int SLOT_IDX_W     = 4;
    localparam int MASK_W         = 8;

    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CREATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STOP   = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

endpackage

// ----- sv/btsp_ctrl.sv -----
module btsp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    output btsp_pkg::ctrl_cmd_t cmd
);
    import btsp_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        done_reg;
    logic        done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy        = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = start;
            end
            ST_EXEC:
            begin
                busy        = 1'b1;
                cmd.execute = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    // The result registers load in the execute cycle and are shown in the next cycle.
    assign done_next = cmd.execute;
    assign done      = done_reg;

endmodule

// ----- sv/btsp_datapath.sv -----
module btsp_datapath #(
    parameter int SLOT_COUNT = btsp_pkg::SLOT_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  btsp_pkg::ctrl_cmd_t             cmd,
    input  logic [btsp_pkg::MODE_W-1:0]     mode,
    input  logic [btsp_pkg::COUNT_W-1:0]    blink_count,
    input  logic [btsp_pkg::PERIOD_W-1:0]   period_ticks,
    input  logic [btsp_pkg::SLOT_IDX_W-1:0] target_slot,
    output logic                            create_ok,
    output logic [btsp_pkg::SLOT_IDX_W-1:0] granted_slot,
    output logic [btsp_pkg::MASK_W-1:0]     fire_mask,
    output logic [btsp_pkg::MASK_W-1:0]     busy_mask
);
    import btsp_pkg::*;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [MODE_W-1:0]     mode_reg;
    logic [COUNT_W-1:0]    limit_in_reg;
    logic [PERIOD_W-1:0]   period_in_reg;
    logic [SLOT_IDX_W-1:0] target_reg;

    logic [SLOT_COUNT-1:0] active_reg;
    logic [SLOT_COUNT-1:0] active_next;
    logic [SLOT_COUNT-1:0] cancelled_reg;
    logic [SLOT_COUNT-1:0] cancelled_next;
    logic [COUNT_W-1:0]    limit_reg     [SLOT_COUNT];
    logic [COUNT_W-1:0]    limit_next    [SLOT_COUNT];
    logic [COUNT_W-1:0]    fires_reg     [SLOT_COUNT];
    logic [COUNT_W-1:0]    fires_next    [SLOT_COUNT];
    logic [PERIOD_W-1:0]   period_reg    [SLOT_COUNT];
    logic [PERIOD_W-1:0]   period_next   [SLOT_COUNT];
    logic [PERIOD_W-1:0]   remaining_reg [SLOT_COUNT];
    logic [PERIOD_W-1:0]   remaining_next[SLOT_COUNT];
    logic [SLOT_COUNT-1:0] fired;

    logic                  free_found;
    logic [SLOT_W-1:0]     free_idx;
    logic                  stop_hit;
    logic [COUNT_W-1:0]    fires_inc;

    logic                  create_ok_reg;
    logic [SLOT_IDX_W-1:0] granted_reg;
    logic [MASK_W-1:0]     fire_mask_reg;
    logic [MASK_W-1:0]     busy_mask_reg;
    logic [SLOT_COUNT+MASK_W-1:0] fired_pad;
    logic [SLOT_COUNT+MASK_W-1:0] active_pad;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg      <= mode;
            limit_in_reg  <= blink_count;
            period_in_reg <= period_ticks;
            target_reg    <= target_slot;
        end
    end

    // Lowest idle slot: scan from the top so the lowest index wins.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign stop_hit = {1'b0, target_reg} < (SLOT_IDX_W + 1)'(SLOT_COUNT);

    always_comb
    begin
        active_next    = active_reg;
        cancelled_next = cancelled_reg;
        limit_next     = limit_reg;
        fires_next     = fires_reg;
        period_next    = period_reg;
        remaining_next = remaining_reg;
        fired          = '0;
        fires_inc      = '0;
        if (cmd.execute)
        begin
            case (mode_reg)
                MODE_TICK:
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        fires_inc = fires_reg[i] + COUNT_W'(1);
                        if (active_reg[i])
                        begin
                            if (remaining_reg[i] > PERIOD_W'(1))
                            begin
                                remaining_next[i] = remaining_reg[i] - PERIOD_W'(1);
                            end
                            else if (cancelled_reg[i])
                            begin
                                active_next[i] = 1'b0;
                            end
                            else
                            begin
                                fired[i] = 1'b1;
                                if (limit_reg[i] != '0)
                                begin
                                    fires_next[i] = fires_inc;
                                end
                                if (limit_reg[i] != '0 && fires_inc == limit_reg[i])
                                begin
                                    active_next[i] = 1'b0;
                                end
                                else
                                begin
                                    remaining_next[i] = (period_reg[i] == '0) ?
                                        PERIOD_W'(1) : period_reg[i];
                                end
                            end
                        end
                    end
                end
                MODE_CREATE:
                begin
                    if (free_found)
                    begin
                        active_next[free_idx]    = 1'b1;
                        cancelled_next[free_idx] = 1'b0;
                        limit_next[free_idx]     = limit_in_reg;
                        fires_next[free_idx]     = '0;
                        period_next[free_idx]    = period_in_reg;
                        remaining_next[free_idx] = (period_in_reg == '0) ?
                            PERIOD_W'(1) : period_in_reg;
                    end
                end
                MODE_STOP:
                begin
                    if (stop_hit)
                    begin
                        cancelled_next[target_reg[SLOT_W-1:0]] = 1'b1;
                    end
                end
                default:
                begin
                    active_next = active_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            cancelled_reg <= '0;
        end
        else
        begin
            active_reg    <= active_next;
            cancelled_reg <= cancelled_next;
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg     <= limit_next;
        fires_reg     <= fires_next;
        period_reg    <= period_next;
        remaining_reg <= remaining_next;
    end

    // Only the low eight slots are visible in the masks; narrow pools pad with zeros.
    assign fired_pad  = {{MASK_W{1'b0}}, fired};
    assign active_pad = {{MASK_W{1'b0}}, active_next};

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            create_ok_reg <= (mode_reg == MODE_CREATE) && free_found;
            granted_reg   <= ((mode_reg == MODE_CREATE) && free_found) ?
                             SLOT_IDX_W'(free_idx) : '0;
            fire_mask_reg <= fired_pad[MASK_W-1:0];
            busy_mask_reg <= active_pad[MASK_W-1:0];
        end
    end

    assign create_ok    = create_ok_reg;
    assign granted_slot = granted_reg;
    assign fire_mask    = fire_mask_reg;
    assign busy_mask    = busy_mask_reg;

endmodule

// ----- sv/blink_timer_slot_pool.sv -----
// Pool of periodic blink timers. Assert start with an item while busy is low; the item is
// taken at that edge, busy is high for the following cycle while the slot registers update,
// and the result appears on the next cycle with done high for exactly one cycle. A new item
// may be started in the same cycle that done is high; while busy is high no new item is
// taken, since the controller runs a capture step and an execute step for each item. The
// receiver cannot stall: each result must be taken in the cycle that done marks it.
module blink_timer_slot_pool #(
    parameter int SLOT_COUNT = btsp_pkg::SLOT_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [btsp_pkg::MODE_W-1:0]     mode,
    input  logic [btsp_pkg::COUNT_W-1:0]    blink_count,
    input  logic [btsp_pkg::PERIOD_W-1:0]   period_ticks,
    input  logic [btsp_pkg::SLOT_IDX_W-1:0] target_slot,
    output logic                            done,
    output logic                            create_ok,
    output logic [btsp_pkg::SLOT_IDX_W-1:0] granted_slot,
    output logic [btsp_pkg::MASK_W-1:0]     fire_mask,
    output logic [btsp_pkg::MASK_W-1:0]     busy_mask
);
    import btsp_pkg::*;

    ctrl_cmd_t cmd;

    btsp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    btsp_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .mode         (mode),
        .blink_count  (blink_count),
        .period_ticks (period_ticks),
        .target_slot  (target_slot),
        .create_ok    (create_ok),
        .granted_slot (granted_slot),
        .fire_mask    (fire_mask),
        .busy_mask    (busy_mask)
    );

`ifndef SYNTH
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a preceding execute cycle");

    a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("execute lasted more than one cycle");

    a_fail_grants_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !create_ok) |-> (granted_slot == '0))
        else $error("granted slot nonzero on a transaction without a grant");

    a_create_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (done && create_ok) |-> (fire_mask == '0))
        else $error("fire mask set on a create transaction");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import btsp_pkg::*;

    localparam int SLOTS = SLOT_COUNT_DEF;
    localparam int CYCLE_LIMIT = 400000;
    // Mode 3 has no defined meaning; the pool must answer it without changing state.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic                  ok;
        logic [SLOT_IDX_W-1:0] slot;
        logic [MASK_W-1:0]     fired;
        logic [MASK_W-1:0]     active;
    } pool_answer_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic [MODE_W-1:0]     mode = MODE_TICK;
    logic [COUNT_W-1:0]    blink_count = '0;
    logic [PERIOD_W-1:0]   period_ticks = '0;
    logic [SLOT_IDX_W-1:0] target_slot = '0;
    logic                  busy;
    logic                  done;
    logic                  create_ok;
    logic [SLOT_IDX_W-1:0] granted_slot;
    logic [MASK_W-1:0]     fire_mask;
    logic [MASK_W-1:0]     busy_mask;

    // Shadow copy of the timer pool, advanced once per accepted transaction.
    logic                slot_on     [SLOTS];
    logic                slot_kill   [SLOTS];
    logic [COUNT_W-1:0]  slot_limit  [SLOTS];
    logic [COUNT_W-1:0]  slot_fires  [SLOTS];
    logic [PERIOD_W-1:0] slot_reload [SLOTS];
    logic [PERIOD_W-1:0] slot_left   [SLOTS];

    pool_answer_t pending_answers[$];
    int           error_count = 0;
    int           cycle_count = 0;

    blink_timer_slot_pool #(
        .SLOT_COUNT(SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .blink_count(blink_count),
        .period_ticks(period_ticks),
        .target_slot(target_slot),
        .done(done),
        .create_ok(create_ok),
        .granted_slot(granted_slot),
        .fire_mask(fire_mask),
        .busy_mask(busy_mask)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic pool_answer_t advance_pool(input logic [MODE_W-1:0] op,
                                                  input logic [COUNT_W-1:0] reps,
                                                  input logic [PERIOD_W-1:0] ticks,
                                                  input logic [SLOT_IDX_W-1:0] slot);
        pool_answer_t ans;
        ans = '0;
        if (op == MODE_TICK)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!slot_on[i])
                    continue;
                if (slot_left[i] > 1)
                    slot_left[i] = slot_left[i] - 1'b1;
                else if (slot_kill[i])
                    slot_on[i] = 1'b0;
                else
                begin
                    if (i < MASK_W)
                        ans.fired[i] = 1'b1;
                    if (slot_limit[i] != 0)
                    begin
                        slot_fires[i] = slot_fires[i] + 1'b1;
                        if (slot_fires[i] == slot_limit[i])
                            slot_on[i] = 1'b0;
                    end
                    if (slot_on[i])
                        slot_left[i] = (slot_reload[i] == 0) ? 16'd1 : slot_reload[i];
                end
            end
        end
        else if (op == MODE_CREATE)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!slot_on[i])
                begin
                    slot_on[i]     = 1'b1;
                    slot_kill[i]   = 1'b0;
                    slot_limit[i]  = reps;
                    slot_fires[i]  = '0;
                    slot_reload[i] = ticks;
                    slot_left[i]   = (ticks == 0) ? 16'd1 : ticks;
                    ans.ok         = 1'b1;
                    ans.slot       = SLOT_IDX_W'(i);
                    break;
                end
            end
        end
        else if (op == MODE_STOP)
        begin
            if (slot < SLOTS)
                slot_kill[slot] = 1'b1;
        end
        for (int i = 0; i < SLOTS && i < MASK_W; i++)
            ans.active[i] = slot_on[i];
        return ans;
    endfunction

    // Present one transaction and hold it until the pool takes it.
    task automatic send_item(input logic [MODE_W-1:0] op, input logic [COUNT_W-1:0] reps,
                             input logic [PERIOD_W-1:0] ticks,
                             input logic [SLOT_IDX_W-1:0] slot);
        start        <= 1'b1;
        mode         <= op;
        blink_count  <= reps;
        period_ticks <= ticks;
        target_slot  <= slot;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_answers.push_back(advance_pool(op, reps, ticks, slot));
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic test_corner_items;
        send_item(MODE_TICK, 8'd0, 16'd0, 4'd0);
        send_item(MODE_SPARE, 8'hFF, 16'hFFFF, 4'hF);
        // A zero period acts as one tick, and a limit of one frees the slot on its first fire.
        send_item(MODE_CREATE, 8'd1, 16'd0, 4'd0);
        send_item(MODE_TICK, 8'd0, 16'd0, 4'd0);
        // Cancelling an idle slot sets a flag that the next create of that slot clears.
        send_item(MODE_STOP, 8'd0, 16'd0, 4'd3);
        send_item(MODE_CREATE, 8'd0, 16'd1, 4'd0);
        send_item(MODE_CREATE, 8'd1, 16'd1, 4'd0);
        send_item(MODE_TICK, 8'd0, 16'd0, 4'd0);
        send_item(MODE_TICK, 8'd0, 16'd0, 4'd0);
        send_item(MODE_STOP, 8'd0, 16'd0, 4'd0);
        send_item(MODE_TICK, 8'd0, 16'd0, 4'd0);
        send_item(MODE_STOP, 8'd0, 16'd0, 4'hF);
        send_item(MODE_STOP, 8'd0, 16'd0, 4'd8);
        for (int k = 0; k < SLOTS - 1; k++)
            send_item(MODE_CREATE, 8'd0, 16'(k + 2), 4'd0);
        // The widest period lands in the last slot and keeps it for the rest of the run.
        send_item(MODE_CREATE, 8'hFF, 16'hFFFF, 4'd0);
        send_item(MODE_CREATE, 8'd3, 16'd5, 4'd0);
        send_item(MODE_TICK, 8'd0, 16'd0, 4'd0);
    endtask

    task automatic test_drain_pause;
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_answers.size() != 0);
    endtask

    task automatic test_random_traffic(input int count, input int quiet_tail);
        int                    pick;
        logic [MODE_W-1:0]     op;
        logic [COUNT_W-1:0]    reps;
        logic [PERIOD_W-1:0]   ticks;
        logic [SLOT_IDX_W-1:0] slot;
        for (int n = 0; n < count; n++)
        begin
            if (n < count - quiet_tail && $urandom_range(3) == 0)
                idle_cycles($urandom_range(17, 1));
            pick  = $urandom_range(99);
            reps  = COUNT_W'($urandom);
            ticks = PERIOD_W'($urandom);
            slot  = SLOT_IDX_W'($urandom);
            if (pick < 52)
                op = MODE_TICK;
            else if (pick < 80)
            begin
                op = MODE_CREATE;
                // Short periods and limits keep slots cycling through fire and release.
                ticks = ($urandom_range(15) == 0) ? 16'($urandom_range(300, 9))
                                                  : 16'($urandom_range(8));
                if ($urandom_range(5) == 0)
                    reps = 8'd0;
                else if ($urandom_range(11) == 0)
                    reps = 8'($urandom_range(255, 7));
                else
                    reps = 8'($urandom_range(6, 1));
            end
            else if (pick < 98)
            begin
                op = MODE_STOP;
                slot = ($urandom_range(7) == 0) ? 4'($urandom_range(15, 8))
                                                : 4'($urandom_range(7));
            end
            else
                op = MODE_SPARE;
            send_item(op, reps, ticks, slot);
        end
    endtask

    always @(posedge clk)
    begin : answer_check
        pool_answer_t want;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: result with no transaction pending", $time);
                error_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (create_ok !== want.ok)
                begin
                    $display("%0t: create_ok expected %0d, got %0d", $time, want.ok, create_ok);
                    error_count++;
                end
                if (granted_slot !== want.slot)
                begin
                    $display("%0t: granted_slot expected %0d, got %0d",
                             $time, want.slot, granted_slot);
                    error_count++;
                end
                if (fire_mask !== want.fired)
                begin
                    $display("%0t: fire_mask expected %h, got %h", $time, want.fired, fire_mask);
                    error_count++;
                end
                if (busy_mask !== want.active)
                begin
                    $display("%0t: busy_mask expected %h, got %h",
                             $time, want.active, busy_mask);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_on[i]     = 1'b0;
            slot_kill[i]   = 1'b0;
            slot_limit[i]  = '0;
            slot_fires[i]  = '0;
            slot_reload[i] = '0;
            slot_left[i]   = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_items;
        test_drain_pause;
        test_random_traffic(900, 0);
        test_drain_pause;
        test_random_traffic(880, 300);

        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
